@@ design/fpp_pkg.sv @@
package fpp_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CMD_W       = 2;
  localparam int IDX_W       = 6;
  localparam int DATA_W      = 32;

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [ADDR_W:0]      pos_t;
  typedef logic [KEY_WIDTH-1:0] key_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_PART  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMD,
    ST_READ,
    ST_PIVOT,
    ST_INEXT,
    ST_SCAN_I,
    ST_JNEXT,
    ST_SCAN_J,
    ST_DECIDE,
    ST_SWAP_I,
    ST_SWAP_J
  } state_t;

  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    key_t  wr_data;
    addr_t rd_addr;
  } store_req_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] read_key;
    addr_t             split_index;
    logic              bad_range;
  } result_t;

  function automatic logic key_less(key_t a, key_t b, logic signed_order);
    key_t sa;
    key_t sb;
    sa = a;
    sb = b;
    if (signed_order) begin
      sa[KEY_WIDTH-1] = ~a[KEY_WIDTH-1];
      sb[KEY_WIDTH-1] = ~b[KEY_WIDTH-1];
    end
    return sa < sb;
  endfunction

endpackage

@@ design/fpp_store.sv @@
module fpp_store (
  input  logic                clk,
  input  fpp_pkg::store_req_t req,
  output fpp_pkg::key_t       rd_data
);

  fpp_pkg::key_t mem [fpp_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

@@ design/fpp_seq.sv @@
module fpp_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  fpp_pkg::cmd_t       cmd_in,
  input  fpp_pkg::addr_t      index_in,
  input  fpp_pkg::key_t       key_in,
  input  fpp_pkg::addr_t      lo_in,
  input  fpp_pkg::addr_t      hi_in,
  input  logic                key_order,
  input  fpp_pkg::key_t       rd_data,
  output fpp_pkg::store_req_t req,
  output fpp_pkg::result_t    res,
  output logic                busy
);

  fpp_pkg::state_t state;
  fpp_pkg::state_t state_next;

  fpp_pkg::cmd_t  cmd_r;
  fpp_pkg::addr_t index_r;
  fpp_pkg::key_t  key_r;
  fpp_pkg::addr_t lo;
  fpp_pkg::addr_t hi;
  fpp_pkg::key_t  pivot;
  fpp_pkg::key_t  pivot_next;
  fpp_pkg::key_t  key_i;
  fpp_pkg::key_t  key_i_next;
  fpp_pkg::key_t  key_j;
  fpp_pkg::key_t  key_j_next;
  fpp_pkg::pos_t  i;
  fpp_pkg::pos_t  i_next;
  fpp_pkg::pos_t  j;
  fpp_pkg::pos_t  j_next;

  logic          less;
  fpp_pkg::pos_t i_inc;
  fpp_pkg::pos_t j_dec;
  fpp_pkg::pos_t lo_ext;
  fpp_pkg::pos_t hi_ext;

  assign less   = fpp_pkg::key_less(rd_data, pivot, key_order);
  assign i_inc  = i + fpp_pkg::pos_t'(1);
  assign j_dec  = j - fpp_pkg::pos_t'(1);
  assign lo_ext = {1'b0, lo};
  assign hi_ext = {1'b0, hi};
  assign busy   = (state != fpp_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= cmd_in;
      index_r <= index_in;
      key_r   <= key_in;
      lo      <= lo_in;
      hi      <= hi_in;
    end
    pivot <= pivot_next;
    key_i <= key_i_next;
    key_j <= key_j_next;
    i     <= i_next;
    j     <= j_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fpp_pkg::ST_IDLE: begin
        if (accept) state_next = fpp_pkg::ST_CMD;
      end
      fpp_pkg::ST_CMD: begin
        unique case (cmd_r)
          fpp_pkg::CMD_WRITE: state_next = fpp_pkg::ST_IDLE;
          fpp_pkg::CMD_READ:  state_next = fpp_pkg::ST_READ;
          fpp_pkg::CMD_PART:  state_next = (lo >= hi) ? fpp_pkg::ST_IDLE : fpp_pkg::ST_PIVOT;
          default:            state_next = fpp_pkg::ST_IDLE;
        endcase
      end
      fpp_pkg::ST_READ:  state_next = fpp_pkg::ST_IDLE;
      fpp_pkg::ST_PIVOT: state_next = fpp_pkg::ST_INEXT;
      fpp_pkg::ST_INEXT: begin
        state_next = (i_inc <= hi_ext) ? fpp_pkg::ST_SCAN_I : fpp_pkg::ST_JNEXT;
      end
      fpp_pkg::ST_SCAN_I: begin
        if (less && (i_inc <= hi_ext)) state_next = fpp_pkg::ST_SCAN_I;
        else                           state_next = fpp_pkg::ST_JNEXT;
      end
      fpp_pkg::ST_JNEXT: begin
        state_next = (j_dec > lo_ext) ? fpp_pkg::ST_SCAN_J : fpp_pkg::ST_DECIDE;
      end
      fpp_pkg::ST_SCAN_J: begin
        if (!less && (j_dec > lo_ext)) state_next = fpp_pkg::ST_SCAN_J;
        else                           state_next = fpp_pkg::ST_DECIDE;
      end
      fpp_pkg::ST_DECIDE: begin
        state_next = (i < j) ? fpp_pkg::ST_SWAP_I : fpp_pkg::ST_IDLE;
      end
      fpp_pkg::ST_SWAP_I: state_next = fpp_pkg::ST_SWAP_J;
      fpp_pkg::ST_SWAP_J: state_next = fpp_pkg::ST_INEXT;
      default:            state_next = fpp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.wr_en   = 1'b0;
    req.wr_addr = i[fpp_pkg::ADDR_W-1:0];
    req.wr_data = key_j;
    req.rd_addr = i_inc[fpp_pkg::ADDR_W-1:0];
    res         = '0;
    pivot_next  = pivot;
    key_i_next  = key_i;
    key_j_next  = key_j;
    i_next      = i;
    j_next      = j;
    unique case (state)
      fpp_pkg::ST_IDLE: begin
      end
      fpp_pkg::ST_CMD: begin
        unique case (cmd_r)
          fpp_pkg::CMD_WRITE: begin
            req.wr_en   = 1'b1;
            req.wr_addr = index_r;
            req.wr_data = key_r;
            res.valid   = 1'b1;
          end
          fpp_pkg::CMD_READ: begin
            req.rd_addr = index_r;
          end
          fpp_pkg::CMD_PART: begin
            req.rd_addr = lo;
            if (lo >= hi) begin
              res.valid       = 1'b1;
              res.split_index = lo;
              res.bad_range   = 1'b1;
            end
          end
          default: begin
            res.valid = 1'b1;
          end
        endcase
      end
      fpp_pkg::ST_READ: begin
        res.valid    = 1'b1;
        res.read_key = fpp_pkg::DATA_W'(rd_data);
      end
      fpp_pkg::ST_PIVOT: begin
        pivot_next = rd_data;
        i_next     = lo_ext;
        j_next     = hi_ext + fpp_pkg::pos_t'(1);
      end
      fpp_pkg::ST_INEXT: begin
        i_next = i_inc;
      end
      fpp_pkg::ST_SCAN_I: begin
        if (less) begin
          i_next = i_inc;
        end else begin
          key_i_next = rd_data;
        end
      end
      fpp_pkg::ST_JNEXT: begin
        j_next      = j_dec;
        req.rd_addr = j_dec[fpp_pkg::ADDR_W-1:0];
      end
      fpp_pkg::ST_SCAN_J: begin
        req.rd_addr = j_dec[fpp_pkg::ADDR_W-1:0];
        if (!less) begin
          j_next = j_dec;
        end else begin
          key_j_next = rd_data;
        end
      end
      fpp_pkg::ST_DECIDE: begin
        if (!(i < j)) begin
          res.valid       = 1'b1;
          res.split_index = j[fpp_pkg::ADDR_W-1:0];
        end
      end
      fpp_pkg::ST_SWAP_I: begin
        req.wr_en   = 1'b1;
        req.wr_addr = i[fpp_pkg::ADDR_W-1:0];
        req.wr_data = key_j;
      end
      fpp_pkg::ST_SWAP_J: begin
        req.wr_en   = 1'b1;
        req.wr_addr = j[fpp_pkg::ADDR_W-1:0];
        req.wr_data = key_i;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/partition_first_pivot_core.sv @@
// Key store of 64 words of 32 bits with an in-place partition about the
// first element of a range.
// Command channel: a word is taken at a clock edge with start high and
// busy low. cmd selects write key at index, read key at index, or
// partition low_bound..high_bound; an unknown cmd returns zeros.
// Result channel: done is high for one cycle with read_key, split_index
// and bad_range; the receiver cannot stall, so the result must be taken
// in that cycle. A new command may be given in the cycle done is high.
// Write, a bad range or an unknown command is answered from the command
// state; a read waits for the registered read data of the store. A
// partition loads the pivot from low_bound, then steps i up and j down
// through the range one element at a time, swaps the two keys while
// i < j and repeats, and answers with j as split_index. The single read
// port of the key store is shared by both pointers; swaps use its write port.
// Configuration: one-bit key_order on cfg_data (0 unsigned, 1 signed),
// written when cfg_valid is high; cfg_ready is always high.
// Reset: clears key_order, the sequencer and done. Store contents are
// undefined until written.
module partition_first_pivot_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [5:0]  index,
  input  logic [31:0] key,
  input  logic [5:0]  low_bound,
  input  logic [5:0]  high_bound,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  output logic        done,
  output logic [31:0] read_key,
  output logic [5:0]  split_index,
  output logic        bad_range
);

  logic                accept;
  logic                key_order;
  fpp_pkg::store_req_t req;
  fpp_pkg::key_t       rd_data;
  fpp_pkg::result_t    res;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_order <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      key_order <= cfg_data;
    end
  end

  fpp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd_in    (fpp_pkg::cmd_t'(cmd)),
    .index_in  (fpp_pkg::ADDR_W'(index)),
    .key_in    (fpp_pkg::KEY_WIDTH'(key)),
    .lo_in     (fpp_pkg::ADDR_W'(low_bound)),
    .hi_in     (fpp_pkg::ADDR_W'(high_bound)),
    .key_order (key_order),
    .rd_data   (rd_data),
    .req       (req),
    .res       (res),
    .busy      (busy)
  );

  fpp_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // hold the result word for its single strobe cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      read_key    <= res.read_key;
      split_index <= fpp_pkg::IDX_W'(res.split_index);
      bad_range   <= res.bad_range;
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequencer busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("accepted word did not start the sequencer");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without preceding work");
  a_bad_no_key: assert property (@(posedge clk) disable iff (rst)
    (done && bad_range) |-> (read_key == 32'd0))
    else $error("bad range result carries a read key");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct {
    logic [31:0] read_key;
    logic [5:0]  split_index;
    logic        bad_range;
  } outcome_t;

  class split_scoreboard;
    fpp_pkg::key_t keys[fpp_pkg::STORE_DEPTH];
    bit            filled[fpp_pkg::STORE_DEPTH];
    bit            signed_order;
    outcome_t      pending_results[$];
    int            fails;

    function bit key_below(fpp_pkg::key_t a, fpp_pkg::key_t b);
      if (signed_order) return $signed(a) < $signed(b);
      return a < b;
    endfunction

    function logic [5:0] split_range(int lo, int hi);
      fpp_pkg::key_t pivot;
      fpp_pkg::key_t t;
      int   i;
      int   j;
      pivot = keys[lo];
      i = lo;
      j = hi + 1;
      while (1) begin
        do i++; while (i <= hi && key_below(keys[i], pivot));
        do j--; while (j > lo && !key_below(keys[j], pivot));
        if (i < j) begin
          t = keys[i];
          keys[i] = keys[j];
          keys[j] = t;
        end else begin
          return j[5:0];
        end
      end
    endfunction

    function void note_word(logic [1:0] c, logic [5:0] idx, logic [31:0] k,
                            logic [5:0] lo, logic [5:0] hi);
      outcome_t r;
      r.read_key = '0;
      r.split_index = '0;
      r.bad_range = 1'b0;
      case (c)
        fpp_pkg::CMD_WRITE: begin
          keys[idx] = k;
          filled[idx] = 1'b1;
        end
        fpp_pkg::CMD_READ: r.read_key = keys[idx];
        fpp_pkg::CMD_PART: begin
          if (lo >= hi) begin
            r.split_index = lo;
            r.bad_range = 1'b1;
          end else begin
            r.split_index = split_range(lo, hi);
          end
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check(logic [31:0] rk, logic [5:0] si, logic br);
      outcome_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no word pending: read_key %h split_index %0d bad_range %0d",
                 $time, rk, si, br);
        fails++;
        return;
      end
      e = pending_results.pop_front();
      if (rk !== e.read_key) begin
        $display("%0t: read_key expected %h actual %h", $time, e.read_key, rk);
        fails++;
      end
      if (si !== e.split_index) begin
        $display("%0t: split_index expected %0d actual %0d", $time, e.split_index, si);
        fails++;
      end
      if (br !== e.bad_range) begin
        $display("%0t: bad_range expected %0d actual %0d", $time, e.bad_range, br);
        fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  cmd;
  logic [5:0]  index;
  logic [31:0] key;
  logic [5:0]  low_bound;
  logic [5:0]  high_bound;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        done;
  logic [31:0] read_key;
  logic [5:0]  split_index;
  logic        bad_range;

  split_scoreboard sb;
  int idle_pct;
  int words_sent;

  partition_first_pivot_core uut (
    .clk,
    .rst,
    .start,
    .busy,
    .cmd,
    .index,
    .key,
    .low_bound,
    .high_bound,
    .cfg_valid,
    .cfg_ready,
    .cfg_data,
    .done,
    .read_key,
    .split_index,
    .bad_range
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("partition_first_pivot_core test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check(read_key, split_index, bad_range);
  end

  function automatic logic [31:0] make_key(int mode);
    case (mode)
      1: return $urandom_range(3);
      2: begin
        case ($urandom_range(3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      3: return ($urandom_range(1) ? 32'h8000_0000 : 32'h0) ^ $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(logic [1:0] c, logic [5:0] idx, logic [31:0] k,
                           logic [5:0] lo, logic [5:0] hi);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    index <= idx;
    key <= k;
    low_bound <= lo;
    high_bound <= hi;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(c, idx, k, lo, hi);
    words_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_order(bit v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.signed_order = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int span;
    int lo_r;
    int hi_r;
    int mode;
    int pos;
    int target;
    bit rewrite;
    sb = new;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    index = '0;
    key = '0;
    low_bound = '0;
    high_bound = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    idle_pct = 0;
    words_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_order(1'b0);
    send_word(fpp_pkg::CMD_WRITE, 6'd0, 32'h8000_0000, 6'd0, 6'd0);
    send_word(fpp_pkg::CMD_WRITE, 6'd1, 32'h0000_0000, 6'd0, 6'd0);
    send_word(fpp_pkg::CMD_WRITE, 6'd2, 32'hFFFF_FFFF, 6'd0, 6'd0);
    send_word(fpp_pkg::CMD_WRITE, 6'd3, 32'h7FFF_FFFF, 6'd0, 6'd0);
    send_word(fpp_pkg::CMD_WRITE, 6'd4, 32'h8000_0000, 6'd0, 6'd0);
    send_word(fpp_pkg::CMD_WRITE, 6'd5, 32'h0000_0001, 6'd0, 6'd0);
    send_word(fpp_pkg::CMD_WRITE, 6'd63, 32'hFFFF_FFFF, 6'd63, 6'd63);
    send_word(fpp_pkg::CMD_READ, 6'd0, 32'hFFFF_FFFF, 6'd63, 6'd63);
    send_word(fpp_pkg::CMD_READ, 6'd63, 32'h0, 6'd0, 6'd0);
    send_word(CMD_UNKNOWN, 6'd63, 32'hFFFF_FFFF, 6'd63, 6'd63);
    send_word(fpp_pkg::CMD_PART, 6'd0, 32'h0, 6'd5, 6'd5);
    send_word(fpp_pkg::CMD_PART, 6'd0, 32'h0, 6'd63, 6'd0);
    send_word(fpp_pkg::CMD_PART, 6'd63, 32'hFFFF_FFFF, 6'd0, 6'd5);
    send_word(fpp_pkg::CMD_READ, 6'd1, 32'h0, 6'd0, 6'd0);
    drain_results();
    write_order(1'b1);
    send_word(fpp_pkg::CMD_PART, 6'd0, 32'h0, 6'd0, 6'd5);
    send_word(fpp_pkg::CMD_PART, 6'd0, 32'h0, 6'd1, 6'd2);
    send_word(fpp_pkg::CMD_WRITE, 6'd62, 32'h0000_0000, 6'd0, 6'd0);
    send_word(fpp_pkg::CMD_PART, 6'd0, 32'h0, 6'd62, 6'd63);
    drain_results();
    write_order(1'b0);
    send_word(fpp_pkg::CMD_PART, 6'd0, 32'h0, 6'd62, 6'd63);
    send_word(fpp_pkg::CMD_READ, 6'd62, 32'h0, 6'd0, 6'd0);

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      write_order(ph % 2 == 0);
      idle_pct = (ph == 1) ? 59 : (ph == 3) ? 38 : 0;
      target = words_sent + 188;
      while (words_sent < target) begin
        if ($urandom_range(99) < 70) begin
          if ($urandom_range(9) == 0) span = $urandom_range(63, 9);
          else span = $urandom_range(8, 1);
          lo_r = $urandom_range(63 - span);
          hi_r = lo_r + span;
          mode = $urandom_range(3);
          rewrite = $urandom_range(1);
          for (int p = lo_r; p <= hi_r; p++) begin
            if (rewrite || !sb.filled[p])
              send_word(fpp_pkg::CMD_WRITE, 6'(p), make_key(mode),
                        6'($urandom), 6'($urandom));
          end
          send_word(fpp_pkg::CMD_PART, 6'($urandom), $urandom, 6'(lo_r), 6'(hi_r));
          repeat ($urandom_range(2)) begin
            pos = $urandom_range(hi_r, lo_r);
            send_word(fpp_pkg::CMD_READ, 6'(pos), $urandom, 6'($urandom), 6'($urandom));
          end
        end else begin
          case ($urandom_range(3))
            0: begin
              pos = $urandom_range(63);
              if (!sb.filled[pos])
                send_word(fpp_pkg::CMD_WRITE, 6'(pos), make_key(0),
                          6'($urandom), 6'($urandom));
              send_word(fpp_pkg::CMD_READ, 6'(pos), $urandom, 6'($urandom), 6'($urandom));
            end
            1: send_word(CMD_UNKNOWN, 6'($urandom), $urandom, 6'($urandom), 6'($urandom));
            2: begin
              lo_r = $urandom_range(63);
              hi_r = $urandom_range(lo_r);
              send_word(fpp_pkg::CMD_PART, 6'($urandom), $urandom, 6'(lo_r), 6'(hi_r));
            end
            default: send_word(fpp_pkg::CMD_WRITE, 6'($urandom), make_key($urandom_range(3)),
                               6'($urandom), 6'($urandom));
          endcase
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.fails == 0) begin
      $display("partition_first_pivot_core test passed");
    end else begin
      $display("partition_first_pivot_core test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/fpp_pkg.sv
design/fpp_store.sv
design/fpp_seq.sv
design/partition_first_pivot_core.sv
test/tb.sv
